FILE: hw/rtl/dmwc_pkg.sv
// shared constants and types of the duplicate message window cache
package dmwc_pkg;

  // table geometry
  localparam int ENTRIES = 32;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  // fixed field widths
  localparam int ID_W     = 16;
  localparam int TIME_W   = 32;
  localparam int SLOT_W   = 5;
  localparam int LCOUNT_W = 6;

  localparam logic [TIME_W-1:0] WINDOW_RESET = TIME_W'(60000);

  // request kinds
  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_INSERT = 1'b1;

  // request held stable during a scan, broadcast to every cell
  typedef struct packed {
    logic              req_type;
    logic [ID_W-1:0]   source_id;
    logic [ID_W-1:0]   message_id;
    logic [TIME_W-1:0] now_ms;
  } dmwc_lookup_t;

  // write command broadcast to every cell
  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  idx;
    logic [ID_W-1:0]   source_id;
    logic [ID_W-1:0]   message_id;
    logic [TIME_W-1:0] seen_ms;
    logic [TIME_W-1:0] end_ms;
  } dmwc_wr_t;

  // scan record handed from cell to cell
  typedef struct packed {
    logic              valid;
    logic              found_match;
    logic [IDX_W-1:0]  match_idx;
    logic              found_dead;
    logic [IDX_W-1:0]  dead_idx;
    logic [TIME_W-1:0] max_age;
    logic [IDX_W-1:0]  oldest_idx;
    logic [CNT_W-1:0]  live_cnt;
  } dmwc_carry_t;

endpackage

FILE: hw/rtl/dmwc_req_if.sv
// request channel interface of the duplicate message window cache
interface dmwc_req_if;
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [dmwc_pkg::ID_W-1:0]   source_id;
  logic [dmwc_pkg::ID_W-1:0]   message_id;
  logic [dmwc_pkg::TIME_W-1:0] now_ms;

  modport source (output valid, req_type, source_id, message_id, now_ms, input ready);
  modport sink   (input valid, req_type, source_id, message_id, now_ms, output ready);
endinterface

FILE: hw/rtl/dmwc_rsp_if.sv
// result channel interface of the duplicate message window cache
interface dmwc_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          hit;
  logic [dmwc_pkg::SLOT_W-1:0]   slot;
  logic                          evicted;
  logic [dmwc_pkg::LCOUNT_W-1:0] live_count;
  logic [dmwc_pkg::TIME_W-1:0]   replacement_total;

  modport source (output valid, hit, slot, evicted, live_count, replacement_total,
                  input ready);
  modport sink   (input valid, hit, slot, evicted, live_count, replacement_total,
                  output ready);
endinterface

FILE: hw/rtl/dmwc_cell.sv
// one table entry with its share of the in-order scan
module dmwc_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [dmwc_pkg::IDX_W-1:0]     idx_i,
  input  dmwc_pkg::dmwc_lookup_t         lookup_i,
  input  dmwc_pkg::dmwc_wr_t             wr_i,
  input  dmwc_pkg::dmwc_carry_t          carry_i,
  output dmwc_pkg::dmwc_carry_t          carry_o
);

  logic                          used_q;
  logic [dmwc_pkg::ID_W-1:0]     src_q;
  logic [dmwc_pkg::ID_W-1:0]     msg_q;
  logic [dmwc_pkg::TIME_W-1:0]   seen_q;
  logic [dmwc_pkg::TIME_W-1:0]   end_q;
  dmwc_pkg::dmwc_carry_t         carry_q;
  dmwc_pkg::dmwc_carry_t         carry_d;

  logic [dmwc_pkg::TIME_W-1:0]   diff;
  logic [dmwc_pkg::TIME_W-1:0]   age;
  logic                          live;
  logic                          match;
  logic                          clear_dead;
  logic                          wr_hit;

  // liveness, match and age of this entry
  always_comb begin
    diff  = end_q - lookup_i.now_ms;
    age   = lookup_i.now_ms - seen_q;
    live  = used_q && (diff != '0) && !diff[dmwc_pkg::TIME_W-1];
    match = live && (src_q == lookup_i.source_id) && (msg_q == lookup_i.message_id);
  end

  // fold this entry into the scan record
  always_comb begin
    carry_d          = carry_i;
    carry_d.live_cnt = carry_i.live_cnt + dmwc_pkg::CNT_W'(live);
    if (!carry_i.found_match && match) begin
      carry_d.found_match = 1'b1;
      carry_d.match_idx   = idx_i;
    end
    if (!carry_i.found_dead) begin
      if (!live) begin
        carry_d.found_dead = 1'b1;
        carry_d.dead_idx   = idx_i;
      end else if (age >= carry_i.max_age) begin
        carry_d.max_age    = age;
        carry_d.oldest_idx = idx_i;
      end
    end
  end

  // expired entries ahead of the first match drop their used bit
  assign clear_dead = carry_i.valid && !carry_i.found_match && used_q && !live;
  assign wr_hit     = wr_i.we && (wr_i.idx == idx_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q  <= 1'b0;
      carry_q <= '0;
    end else begin
      carry_q <= carry_d;
      if (wr_hit) begin
        used_q <= 1'b1;
      end else if (clear_dead) begin
        used_q <= 1'b0;
      end
    end
  end

  // entry payload
  always_ff @(posedge clk_i) begin
    if (wr_hit) begin
      src_q  <= wr_i.source_id;
      msg_q  <= wr_i.message_id;
      seen_q <= wr_i.seen_ms;
      end_q  <= wr_i.end_ms;
    end
  end

  assign carry_o = carry_q;

endmodule

FILE: hw/rtl/duplicate_message_window_cache_core.sv
// one item at a time: a request is accepted only while idle, after the previous item
// has written its result; the scan record steps one cell per cycle down the chain of
// entry cells, then the done state writes the chosen cell and loads the result once the
// output register is free; a finished result waits there while the next item is accepted
// reset: all entries unused, eviction count zero, window at 60000 ms; no clearing pass
module duplicate_message_window_cache_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [dmwc_pkg::TIME_W-1:0]    cfg_data_i,
  dmwc_req_if.sink                       req_i,
  dmwc_rsp_if.source                     rsp_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  state_e                          state_q;
  logic                            start_q;
  dmwc_pkg::dmwc_lookup_t          lookup_q;
  dmwc_pkg::dmwc_carry_t           fin_q;
  logic [dmwc_pkg::TIME_W-1:0]     window_q;
  logic [dmwc_pkg::TIME_W-1:0]     evict_cnt_q;

  logic                            rsp_valid_q;
  logic                            rsp_hit_q;
  logic [dmwc_pkg::SLOT_W-1:0]     rsp_slot_q;
  logic                            rsp_evicted_q;
  logic [dmwc_pkg::LCOUNT_W-1:0]   rsp_live_q;

  dmwc_pkg::dmwc_carry_t           chain [dmwc_pkg::ENTRIES+1];
  dmwc_pkg::dmwc_wr_t              wr;

  logic                            req_fire;
  logic                            done_fire;
  logic                            hit;
  logic                            evict;
  logic                            is_insert;
  logic                            new_live;
  logic [dmwc_pkg::IDX_W-1:0]      tgt_idx;
  logic [dmwc_pkg::IDX_W-1:0]      slot_idx;
  logic [dmwc_pkg::CNT_W-1:0]      live_after;
  logic [dmwc_pkg::IDX_W+dmwc_pkg::SLOT_W-1:0]   slot_ext;
  logic [dmwc_pkg::CNT_W+dmwc_pkg::LCOUNT_W-1:0] live_ext;

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;

  // scan record entering the first cell
  always_comb begin
    chain[0]       = '0;
    chain[0].valid = start_q;
  end

  // chain of entry cells
  for (genvar g = 0; g < dmwc_pkg::ENTRIES; g++) begin : g_cell
    dmwc_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .idx_i    (dmwc_pkg::IDX_W'(g)),
      .lookup_i (lookup_q),
      .wr_i     (wr),
      .carry_i  (chain[g]),
      .carry_o  (chain[g+1])
    );
  end

  // outcome of the finished scan
  always_comb begin
    is_insert = (lookup_q.req_type == dmwc_pkg::REQ_INSERT);
    hit       = fin_q.found_match;
    evict     = is_insert && !hit && !fin_q.found_dead;
    if (hit) begin
      tgt_idx = fin_q.match_idx;
    end else if (fin_q.found_dead) begin
      tgt_idx = fin_q.dead_idx;
    end else begin
      tgt_idx = fin_q.oldest_idx;
    end
    slot_idx   = (hit || is_insert) ? tgt_idx : '0;
    new_live   = (window_q != '0) && !window_q[dmwc_pkg::TIME_W-1];
    live_after = fin_q.live_cnt
               - dmwc_pkg::CNT_W'(is_insert && (hit || evict))
               + dmwc_pkg::CNT_W'(is_insert && new_live);
    slot_ext   = {{dmwc_pkg::SLOT_W{1'b0}}, slot_idx};
    live_ext   = {{dmwc_pkg::LCOUNT_W{1'b0}}, live_after};
    done_fire  = (state_q == ST_DONE) && (!rsp_valid_q || rsp_o.ready);
  end

  // table write at the end of an insert
  always_comb begin
    wr.we         = done_fire && is_insert;
    wr.idx        = tgt_idx;
    wr.source_id  = lookup_q.source_id;
    wr.message_id = lookup_q.message_id;
    wr.seen_ms    = lookup_q.now_ms;
    wr.end_ms     = lookup_q.now_ms + window_q;
  end

  // control, configuration and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      start_q     <= 1'b0;
      window_q    <= dmwc_pkg::WINDOW_RESET;
      evict_cnt_q <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      start_q <= 1'b0;
      if (cfg_we_i) begin
        window_q <= cfg_data_i;
      end
      if (rsp_valid_q && rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (req_fire) begin
            start_q <= 1'b1;
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (chain[dmwc_pkg::ENTRIES].valid) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (done_fire) begin
            rsp_valid_q <= 1'b1;
            evict_cnt_q <= evict_cnt_q + dmwc_pkg::TIME_W'(evict);
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // request, scan result and result payload
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      lookup_q.req_type   <= req_i.req_type;
      lookup_q.source_id  <= req_i.source_id;
      lookup_q.message_id <= req_i.message_id;
      lookup_q.now_ms     <= req_i.now_ms;
    end
    if (state_q == ST_SCAN && chain[dmwc_pkg::ENTRIES].valid) begin
      fin_q <= chain[dmwc_pkg::ENTRIES];
    end
    if (done_fire) begin
      rsp_hit_q     <= hit;
      rsp_slot_q    <= slot_ext[dmwc_pkg::SLOT_W-1:0];
      rsp_evicted_q <= evict;
      rsp_live_q    <= live_ext[dmwc_pkg::LCOUNT_W-1:0];
    end
  end

  assign rsp_o.valid             = rsp_valid_q;
  assign rsp_o.hit               = rsp_hit_q;
  assign rsp_o.slot              = rsp_slot_q;
  assign rsp_o.evicted           = rsp_evicted_q;
  assign rsp_o.live_count        = rsp_live_q;
  assign rsp_o.replacement_total = evict_cnt_q;

endmodule

FILE: hw/rtl/dmwc_checker.sv
// port-level checks of the duplicate message window cache, bound to the top level
module dmwc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          req_valid_i,
  input logic                          req_ready_i,
  input logic                          rsp_valid_i,
  input logic                          rsp_ready_i,
  input logic                          hit_i,
  input logic                          evicted_i,
  input logic [dmwc_pkg::SLOT_W-1:0]   slot_i,
  input logic [dmwc_pkg::TIME_W-1:0]   total_i
);

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(slot_i) && $stable(total_i))
    else $error("stalled result changed");

  // one item at a time: no new request right after an accept
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while busy");

  // a new result only comes out of a busy block
  a_rsp_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_i) |-> !$past(req_ready_i))
    else $error("result without a request in flight");

  // an eviction never comes with a hit
  a_evict_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && evicted_i |-> !hit_i)
    else $error("eviction reported on a hit");

endmodule

bind duplicate_message_window_cache_core dmwc_checker u_dmwc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .hit_i       (rsp_o.hit),
  .evicted_i   (rsp_o.evicted),
  .slot_i      (rsp_o.slot),
  .total_i     (rsp_o.replacement_total)
);
